// File: hw/rtl/lanczos3_image_upscaler_unit_macros.svh
// ----------------------------------------------------------------------------
// lanczos3 image upscaler assertion macros
// property shorthands clocked on a named clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LANCZOS3_IMAGE_UPSCALER_UNIT_MACROS_SVH
`define LANCZOS3_IMAGE_UPSCALER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LZ3UP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LZ3UP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lz3up_pkg.sv
// ----------------------------------------------------------------------------
// lz3up_pkg
// shared types, constants, weight table and helpers of the lanczos3 upscaler
// ----------------------------------------------------------------------------
`default_nettype none

package lz3up_pkg;

    localparam int TAP_COUNT   = 6;
    localparam int TAP_W       = 3;
    localparam int MAX_SCALE   = 4;
    localparam int TABLE_FRAC  = 14;
    localparam int DIM_W       = 7;
    localparam int COORD_W     = 8;
    localparam int SCALE_W     = 3;
    localparam int PIX_W       = 32;
    localparam int CHAN_W      = 8;
    localparam int CHANNELS    = 4;
    localparam int TROW_COUNT  = 9;
    localparam int TROW_W      = 4;
    localparam int TBL_W       = 16;
    localparam int WSCALE_W    = 48;
    localparam int FX_W        = 10;
    localparam int PHASE_W     = 2;
    localparam int REG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // divide by three for 8-bit values: (c * 171) >> 9 is exact
    localparam int DIV3_MUL    = 171;
    localparam int DIV3_SHIFT  = 9;

    localparam logic [REG_IDX_W-1:0] REG_SCALE      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAP,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        KIND_ERROR,
        KIND_PASS,
        KIND_RESAMPLE
    } result_kind_t;

    typedef struct packed {
        logic start_taps;
        logic start_result;
        logic out_free;
    } seq_in_t;

    typedef struct packed {
        logic             idle;
        logic             tap_issue;
        logic [TAP_W-1:0] tap_k;
        logic [TAP_W-1:0] tap_m;
        logic             load_out;
    } seq_out_t;

    typedef struct packed {
        logic signed [FX_W-1:0] org;
        logic [PHASE_W-1:0]     phase;
    } origin_t;

    typedef logic signed [TBL_W-1:0] tbl_word_t;

    // rows: scale 2 phases 0..1, scale 3 phases 0..2, scale 4 phases 0..3
    localparam tbl_word_t LZ_TABLE [TROW_COUNT][TAP_COUNT] = '{
        '{  121, -1114,  4440, 14628, -2184,  493 },
        '{  493, -2184, 14628,  4440, -1114,  121 },
        '{  208, -1536,  6265, 13336, -2400,  511 },
        '{    0,     0, 16384,     0,     0,    0 },
        '{  511, -2400, 13336,  6265, -1536,  208 },
        '{  257, -1736,  7206, 12583, -2425,  499 },
        '{   30,  -501,  1977, 15936, -1393,  335 },
        '{  335, -1393, 15936,  1977,  -501,   30 },
        '{  499, -2425, 12583,  7206, -1736,  257 }
    };

    // first table row of each scale
    localparam logic [TROW_W-1:0] TROW_BASE [MAX_SCALE+1] = '{ 0, 0, 0, 2, 5 };

    // table weight moved to frac fraction bits, round half up
    function automatic logic signed [WSCALE_W-1:0] scaled_weight(tbl_word_t w, int frac);
        logic signed [WSCALE_W-1:0] n;
        n = WSCALE_W'(w) <<< frac;
        return (n + (WSCALE_W'(1) <<< (TABLE_FRAC - 1))) >>> TABLE_FRAC;
    endfunction

    // first tap origin and phase of a destination coordinate at scale s
    function automatic origin_t tap_origin(logic [COORD_W-1:0] c, logic [SCALE_W-1:0] s);
        logic [2*COORD_W-1:0] prod;
        logic [COORD_W-1:0]   q;
        logic [PHASE_W-1:0]   p;
        logic                 up;
        origin_t              o;
        prod = (2*COORD_W)'(c) * (2*COORD_W)'(DIV3_MUL);
        q    = c;
        p    = '0;
        unique case (s)
            3'd2: begin
                q = c >> 1;
                p = PHASE_W'(c[0]);
            end
            3'd3: begin
                q = COORD_W'(prod >> DIV3_SHIFT);
                p = PHASE_W'(c - COORD_W'(q * COORD_W'(3)));
            end
            3'd4: begin
                q = c >> 2;
                p = c[1:0];
            end
            default: begin
                q = c;
                p = '0;
            end
        endcase
        // center tap moves up one when 2*phase+1 reaches the scale
        up      = ({1'b0, p, 1'b1} >= {1'b0, s});
        o.org   = $signed({{(FX_W-COORD_W){1'b0}}, q})
                + $signed({{(FX_W-1){1'b0}}, up}) - FX_W'(1);
        o.phase = p;
        return o;
    endfunction

    // clamp a tap position into 0..n-1
    function automatic logic [DIM_W-1:0] clamp_idx(logic signed [FX_W-1:0] v,
                                                   logic [DIM_W-1:0] n);
        if (v < 0) begin
            return '0;
        end
        if (v >= $signed({{(FX_W-DIM_W){1'b0}}, n})) begin
            return n - DIM_W'(1);
        end
        return v[DIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lanczos3_image_upscaler_unit.sv
// ----------------------------------------------------------------------------
// lanczos3_image_upscaler_unit
// integer-factor lanczos-3 upscaler over a stored argb source frame
// ----------------------------------------------------------------------------
// A write request stores one source pixel if it lies inside the source frame
// and is taken every cycle while the sequencer is idle. A read request
// returns one destination pixel. At scale 2..4 the block reads the 6x6
// source taps one per cycle through the single frame memory port and feeds
// a shared multiply-accumulate unit that handles all four channels of a tap
// at once, then passes a drain and a result state; pass-through and
// out-of-frame requests go straight to the result state. The result sits in
// an output register, so writes and the next request go on while it waits.
// The frame memory has no clearing pass: read pixels only after writing.
`default_nettype none

`include "lanczos3_image_upscaler_unit_macros.svh"

module lanczos3_image_upscaler_unit #(
    parameter int MAX_WIDTH        = 64,
    parameter int MAX_HEIGHT       = 64,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_cmd,
    input  wire logic [lz3up_pkg::COORD_W-1:0]        s_col,
    input  wire logic [lz3up_pkg::COORD_W-1:0]        s_row,
    input  wire logic [lz3up_pkg::PIX_W-1:0]          s_argb_in,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [lz3up_pkg::PIX_W-1:0]               m_argb_out,
    output logic                                      m_status,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lz3up_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire logic [lz3up_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WW     = WEIGHT_FRAC_BITS + 2;
    localparam int DIM_W  = lz3up_pkg::DIM_W;
    localparam int DST_W  = lz3up_pkg::DIM_W + lz3up_pkg::SCALE_W;
    localparam int FX_W   = lz3up_pkg::FX_W;
    localparam int TAP_W  = lz3up_pkg::TAP_W;

    // configuration
    logic [lz3up_pkg::SCALE_W-1:0] scale_reg;
    logic [DIM_W-1:0]              src_width_reg;
    logic [DIM_W-1:0]              src_height_reg;

    logic [lz3up_pkg::SCALE_W-1:0] s_eff;
    logic [DIM_W-1:0]              sw;
    logic [DIM_W-1:0]              sh;
    logic [DST_W-1:0]              dst_w;
    logic [DST_W-1:0]              dst_h;

    // request decode
    logic                          acc_in;
    logic                          is_wr;
    logic                          is_rd;
    logic                          wr_ok;
    logic                          req_oob;
    lz3up_pkg::result_kind_t       req_kind;
    lz3up_pkg::origin_t            ox;
    lz3up_pkg::origin_t            oy;
    logic [ADDR_W-1:0]             acc_addr;

    // per-request state
    lz3up_pkg::result_kind_t       kind_reg;
    logic signed [FX_W-1:0]        org_x_reg;
    logic signed [FX_W-1:0]        org_y_reg;
    logic [lz3up_pkg::TROW_W-1:0]  trow_x_reg;
    logic [lz3up_pkg::TROW_W-1:0]  trow_y_reg;

    // tap path
    lz3up_pkg::seq_in_t            seq_in;
    lz3up_pkg::seq_out_t           seq_out;
    logic signed [FX_W-1:0]        tap_x;
    logic signed [FX_W-1:0]        tap_y;
    logic [DIM_W-1:0]              ix;
    logic [DIM_W-1:0]              iy;
    logic [ADDR_W-1:0]             tap_addr;
    logic signed [WW-1:0]          wx;
    logic signed [WW-1:0]          wy;

    // memory port
    logic                          ram_en;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_addr;
    logic [lz3up_pkg::PIX_W-1:0]   ram_rdata;
    logic [lz3up_pkg::PIX_W-1:0]   mac_result;

    // result port
    logic                          m_valid_reg, m_valid_next;
    logic [lz3up_pkg::PIX_W-1:0]   m_argb_reg, m_argb_next;
    logic                          m_status_reg, m_status_next;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > maxv) begin
            return DIM_W'(maxv);
        end
        return v;
    endfunction

    // ---------------- configuration ----------------

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= lz3up_pkg::SCALE_W'(1);
            src_width_reg  <= DIM_W'(64);
            src_height_reg <= DIM_W'(64);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lz3up_pkg::REG_SCALE: begin
                    scale_reg <= cfg_data[lz3up_pkg::SCALE_W-1:0];
                end
                lz3up_pkg::REG_SRC_WIDTH: begin
                    src_width_reg <= cfg_data;
                end
                lz3up_pkg::REG_SRC_HEIGHT: begin
                    src_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign sw    = eff_dim(src_width_reg, MAX_WIDTH);
    assign sh    = eff_dim(src_height_reg, MAX_HEIGHT);
    assign s_eff = (scale_reg >= lz3up_pkg::SCALE_W'(2) &&
                    scale_reg <= lz3up_pkg::SCALE_W'(lz3up_pkg::MAX_SCALE))
                   ? scale_reg : lz3up_pkg::SCALE_W'(1);
    assign dst_w = DST_W'(sw) * DST_W'(s_eff);
    assign dst_h = DST_W'(sh) * DST_W'(s_eff);

    // ---------------- request decode ----------------

    assign s_ready = seq_out.idle;
    assign acc_in  = s_valid && s_ready;
    assign is_wr   = (s_cmd == lz3up_pkg::CMD_WRITE);
    assign is_rd   = (s_cmd == lz3up_pkg::CMD_READ);
    assign wr_ok   = (s_col < lz3up_pkg::COORD_W'(sw)) && (s_row < lz3up_pkg::COORD_W'(sh));
    assign req_oob = (DST_W'(s_col) >= dst_w) || (DST_W'(s_row) >= dst_h);

    always_comb begin
        if (req_oob) begin
            req_kind = lz3up_pkg::KIND_ERROR;
        end else if (s_eff == lz3up_pkg::SCALE_W'(1)) begin
            req_kind = lz3up_pkg::KIND_PASS;
        end else begin
            req_kind = lz3up_pkg::KIND_RESAMPLE;
        end
    end

    assign ox       = lz3up_pkg::tap_origin(s_col, s_eff);
    assign oy       = lz3up_pkg::tap_origin(s_row, s_eff);
    assign acc_addr = ADDR_W'(s_row[DIM_W-1:0]) * ADDR_W'(MAX_WIDTH)
                    + ADDR_W'(s_col[DIM_W-1:0]);

    assign seq_in.start_taps   = acc_in && is_rd && (req_kind == lz3up_pkg::KIND_RESAMPLE);
    assign seq_in.start_result = acc_in && is_rd && (req_kind != lz3up_pkg::KIND_RESAMPLE);
    assign seq_in.out_free     = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (acc_in && is_rd) begin
            kind_reg   <= req_kind;
            org_x_reg  <= ox.org;
            org_y_reg  <= oy.org;
            trow_x_reg <= lz3up_pkg::TROW_BASE[s_eff] + lz3up_pkg::TROW_W'(ox.phase);
            trow_y_reg <= lz3up_pkg::TROW_BASE[s_eff] + lz3up_pkg::TROW_W'(oy.phase);
        end
    end

    lz3up_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq_in  (seq_in),
        .seq_out (seq_out)
    );

    // ---------------- tap address and weights ----------------

    // taps run from origin-2 to origin+3
    assign tap_x = org_x_reg + $signed({{(FX_W-TAP_W){1'b0}}, seq_out.tap_k}) - FX_W'(2);
    assign tap_y = org_y_reg + $signed({{(FX_W-TAP_W){1'b0}}, seq_out.tap_m}) - FX_W'(2);
    assign ix    = lz3up_pkg::clamp_idx(tap_x, sw);
    assign iy    = lz3up_pkg::clamp_idx(tap_y, sh);
    assign tap_addr = ADDR_W'(iy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ix);

    assign wx = WW'(lz3up_pkg::scaled_weight(
                    lz3up_pkg::LZ_TABLE[trow_x_reg][seq_out.tap_k], WEIGHT_FRAC_BITS));
    assign wy = WW'(lz3up_pkg::scaled_weight(
                    lz3up_pkg::LZ_TABLE[trow_y_reg][seq_out.tap_m], WEIGHT_FRAC_BITS));

    // ---------------- frame memory and accumulator ----------------

    assign ram_we   = acc_in && is_wr && wr_ok;
    assign ram_en   = ram_we || seq_out.tap_issue ||
                      (acc_in && is_rd && (req_kind == lz3up_pkg::KIND_PASS));
    assign ram_addr = seq_out.tap_issue ? tap_addr : acc_addr;

    lz3up_frame_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (lz3up_pkg::PIX_W)
    ) u_frame_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_argb_in),
        .rdata (ram_rdata)
    );

    lz3up_mac #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (seq_in.start_taps),
        .issue   (seq_out.tap_issue),
        .wx      (wx),
        .wy      (wy),
        .pixel   (ram_rdata),
        .result  (mac_result)
    );

    // ---------------- result register ----------------

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_argb_next   = m_argb_reg;
        m_status_next = m_status_reg;
        if (seq_out.load_out) begin
            m_valid_next = 1'b1;
            unique case (kind_reg)
                lz3up_pkg::KIND_PASS: begin
                    m_argb_next   = ram_rdata;
                    m_status_next = 1'b0;
                end
                lz3up_pkg::KIND_RESAMPLE: begin
                    m_argb_next   = mac_result;
                    m_status_next = 1'b0;
                end
                default: begin
                    m_argb_next   = '0;
                    m_status_next = 1'b1;
                end
            endcase
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_argb_reg   <= m_argb_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_argb_out = m_argb_reg;
    assign m_status   = m_status_reg;

    // ---------------- assertions ----------------

    `LZ3UP_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_status, m_argb_out == '0, "error result carries pixel data")
    `LZ3UP_ASSERT_NOW(a_tap_count, aclk, aresetn, seq_in.start_taps, ##36 seq_out.tap_issue ##1 !seq_out.tap_issue, "resample did not issue exactly 36 taps")
    `LZ3UP_ASSERT_NEXT(a_write_quiet, aclk, aresetn, s_valid && s_ready && s_cmd == lz3up_pkg::CMD_WRITE, seq_out.idle && !seq_out.load_out, "write request left the sequencer busy")

endmodule

`default_nettype wire

// File: hw/rtl/lz3up_frame_ram.sv
// ----------------------------------------------------------------------------
// lz3up_frame_ram
// single port source frame memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lz3up_frame_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lz3up_seq.sv
// ----------------------------------------------------------------------------
// lz3up_seq
// request sequencer: walks the 6x6 tap grid and hands the result to the port
// ----------------------------------------------------------------------------
`default_nettype none

module lz3up_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lz3up_pkg::seq_in_t seq_in,
    output lz3up_pkg::seq_out_t     seq_out
);

    localparam logic [lz3up_pkg::TAP_W-1:0] TAP_LAST =
        lz3up_pkg::TAP_W'(lz3up_pkg::TAP_COUNT - 1);

    lz3up_pkg::seq_state_t            state_reg, state_next;
    logic [lz3up_pkg::TAP_W-1:0]      k_reg, k_next;
    logic [lz3up_pkg::TAP_W-1:0]      m_reg, m_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lz3up_pkg::ST_IDLE;
            k_reg     <= '0;
            m_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        k_next            = k_reg;
        m_next            = m_reg;
        seq_out           = '0;
        seq_out.tap_k     = k_reg;
        seq_out.tap_m     = m_reg;
        unique case (state_reg)
            lz3up_pkg::ST_IDLE: begin
                seq_out.idle = 1'b1;
                k_next       = '0;
                m_next       = '0;
                if (seq_in.start_taps) begin
                    state_next = lz3up_pkg::ST_TAP;
                end else if (seq_in.start_result) begin
                    state_next = lz3up_pkg::ST_DONE;
                end
            end
            lz3up_pkg::ST_TAP: begin
                seq_out.tap_issue = 1'b1;
                if (k_reg == TAP_LAST) begin
                    k_next = '0;
                    if (m_reg == TAP_LAST) begin
                        state_next = lz3up_pkg::ST_DRAIN;
                    end else begin
                        m_next = m_reg + lz3up_pkg::TAP_W'(1);
                    end
                end else begin
                    k_next = k_reg + lz3up_pkg::TAP_W'(1);
                end
            end
            // last tap still in the multiply-accumulate stage
            lz3up_pkg::ST_DRAIN: begin
                state_next = lz3up_pkg::ST_DONE;
            end
            lz3up_pkg::ST_DONE: begin
                if (seq_in.out_free) begin
                    seq_out.load_out = 1'b1;
                    state_next       = lz3up_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lz3up_mac.sv
// ----------------------------------------------------------------------------
// lz3up_mac
// shared weight multiplier and four-lane channel accumulator with rounding
// ----------------------------------------------------------------------------
`default_nettype none

module lz3up_mac #(
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  clear,
    input  wire logic                                  issue,
    input  wire logic signed [WEIGHT_FRAC_BITS+1:0]    wx,
    input  wire logic signed [WEIGHT_FRAC_BITS+1:0]    wy,
    input  wire logic [lz3up_pkg::PIX_W-1:0]           pixel,
    output logic      [lz3up_pkg::PIX_W-1:0]           result
);

    localparam int WW     = WEIGHT_FRAC_BITS + 2;
    localparam int WP_W   = 2 * WW;
    localparam int PR_W   = WP_W + lz3up_pkg::CHAN_W + 1;
    localparam int ACC_W  = 2 * WEIGHT_FRAC_BITS + 14;
    localparam int OUT_SH = 2 * WEIGHT_FRAC_BITS;
    localparam int CW     = lz3up_pkg::CHAN_W;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (OUT_SH - 1);
    localparam logic signed [ACC_W-1:0] CHAN_MAX = ACC_W'((1 << CW) - 1);

    logic signed [WP_W-1:0]  wprod_reg;
    logic                    vld_reg, vld_next;
    logic signed [ACC_W-1:0] acc_reg  [lz3up_pkg::CHANNELS];
    logic signed [ACC_W-1:0] acc_next [lz3up_pkg::CHANNELS];
    logic signed [PR_W-1:0]  prod     [lz3up_pkg::CHANNELS];

    // sum is in 2*frac fraction bits: add half, floor, clamp to 0..255
    function automatic logic [CW-1:0] round_chan(logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] v;
        t = a + RND_HALF;
        v = t >>> OUT_SH;
        if (t < 0) begin
            return '0;
        end
        if (v > CHAN_MAX) begin
            return '1;
        end
        return v[CW-1:0];
    endfunction

    assign vld_next = issue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        wprod_reg <= wx * wy;
        for (int c = 0; c < lz3up_pkg::CHANNELS; c++) begin
            acc_reg[c] <= acc_next[c];
        end
    end

    always_comb begin
        for (int c = 0; c < lz3up_pkg::CHANNELS; c++) begin
            prod[c] = $signed({1'b0, pixel[c*CW +: CW]}) * wprod_reg;
            if (clear) begin
                acc_next[c] = '0;
            end else if (vld_reg) begin
                acc_next[c] = acc_reg[c] + ACC_W'(prod[c]);
            end else begin
                acc_next[c] = acc_reg[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < lz3up_pkg::CHANNELS; c++) begin
            result[c*CW +: CW] = round_chan(acc_reg[c]);
        end
    end

endmodule

`default_nettype wire

// File: test/lanczos3_image_upscaler_unit_tb.sv
// ----------------------------------------------------------------------------
// lanczos3_image_upscaler_unit_tb
// writes source frames of random size, requests destination pixels at every
// scale setting and checks each pixel against a bit-exact lanczos-3 predictor
// ----------------------------------------------------------------------------

module lanczos3_image_upscaler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lz3up_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int ITEM_GOAL      = 1700;
    localparam int SETTLE_CYCLES  = 45;
    localparam int WATCHDOG_LIMIT = 2000;

    class resample_tracker;
        localparam int STORE_COLS  = 64;
        localparam int STORE_ROWS  = 64;
        localparam int TAPS        = 6;
        localparam int TABLE_FRAC  = 14;
        localparam int WEIGHT_FRAC = 14;

        // scale 2 phases 0..1, scale 3 phases 0..2, scale 4 phases 0..3
        int kernel_rows [9][TAPS] = '{
            '{  121, -1114,  4440, 14628, -2184,  493 },
            '{  493, -2184, 14628,  4440, -1114,  121 },
            '{  208, -1536,  6265, 13336, -2400,  511 },
            '{    0,     0, 16384,     0,     0,    0 },
            '{  511, -2400, 13336,  6265, -1536,  208 },
            '{  257, -1736,  7206, 12583, -2425,  499 },
            '{   30,  -501,  1977, 15936, -1393,  335 },
            '{  335, -1393, 15936,  1977,  -501,   30 },
            '{  499, -2425, 12583,  7206, -1736,  257 }
        };

        bit [31:0] frame [STORE_COLS*STORE_ROWS];
        bit [2:0]  scale_reg  = 3'd1;
        bit [6:0]  width_reg  = 7'd64;
        bit [6:0]  height_reg = 7'd64;
        bit [31:0] pending_argb [$];
        bit        pending_status [$];
        int        mismatch_count = 0;

        function int unsigned fit_dim(bit [6:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function int unsigned source_width();
            return fit_dim(width_reg, STORE_COLS);
        endfunction

        function int unsigned source_height();
            return fit_dim(height_reg, STORE_ROWS);
        endfunction

        function int unsigned upscale_factor();
            return (scale_reg >= 3'd2 && scale_reg <= 3'd4) ? int'(scale_reg) : 1;
        endfunction

        function void set_reg(bit [1:0] idx, bit [6:0] data);
            case (idx)
                lz3up_pkg::REG_SCALE: scale_reg = data[2:0];
                lz3up_pkg::REG_SRC_WIDTH: width_reg = data;
                lz3up_pkg::REG_SRC_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function longint q14_weight(int w);
            longint n;
            n = longint'(w) <<< WEIGHT_FRAC;
            return (n + (longint'(1) <<< (TABLE_FRAC - 1))) >>> TABLE_FRAC;
        endfunction

        function int tap_pos(int v, int n);
            if (v < 0) return 0;
            if (v >= n) return n - 1;
            return v;
        endfunction

        function bit [7:0] round_channel(longint acc);
            longint t;
            t = acc + (longint'(1) <<< (2*WEIGHT_FRAC - 1));
            if (t < 0) return 8'h00;
            t = t >>> (2*WEIGHT_FRAC);
            if (t > 255) return 8'hFF;
            return t[7:0];
        endfunction

        function void resample(bit [7:0] col, bit [7:0] row,
                               output bit [31:0] argb, output bit status);
            int unsigned sw, sh, f, base;
            int          ox, oy, k, m, c;
            int          ix [TAPS];
            int          iy [TAPS];
            longint      wx [TAPS];
            longint      wy [TAPS];
            longint      acc [4];
            bit [31:0]   p;
            sw = source_width();
            sh = source_height();
            f = upscale_factor();
            argb = '0;
            status = 1'b0;
            if (col >= sw*f || row >= sh*f) begin
                status = 1'b1;
                return;
            end
            if (f == 1) begin
                argb = frame[row*STORE_COLS + col];
                return;
            end
            base = (f == 2) ? 0 : (f == 3) ? 2 : 5;
            // tap origin sits on the source pixel at or left of the sample point
            ox = int'((2*col + 1 + f) / (2*f)) - 1;
            oy = int'((2*row + 1 + f) / (2*f)) - 1;
            for (k = 0; k < TAPS; k++) begin
                wx[k] = q14_weight(kernel_rows[base + col % f][k]);
                wy[k] = q14_weight(kernel_rows[base + row % f][k]);
                ix[k] = tap_pos(ox - 2 + k, int'(sw));
                iy[k] = tap_pos(oy - 2 + k, int'(sh));
            end
            for (c = 0; c < 4; c++) acc[c] = 0;
            for (m = 0; m < TAPS; m++) begin
                for (k = 0; k < TAPS; k++) begin
                    p = frame[iy[m]*STORE_COLS + ix[k]];
                    for (c = 0; c < 4; c++) begin
                        acc[c] += longint'(p[8*c +: 8]) * wx[k] * wy[m];
                    end
                end
            end
            for (c = 0; c < 4; c++) argb[8*c +: 8] = round_channel(acc[c]);
        endfunction

        // returns 1 unless the item is a write that the block drops
        function bit note_request(bit cmd, bit [7:0] col, bit [7:0] row, bit [31:0] argb);
            bit [31:0] pix;
            bit        st;
            if (cmd == lz3up_pkg::CMD_WRITE) begin
                if (col < source_width() && row < source_height()) begin
                    frame[row*STORE_COLS + col] = argb;
                    return 1'b1;
                end
                return 1'b0;
            end
            resample(col, row, pix, st);
            pending_argb = {pending_argb, pix};
            pending_status = {pending_status, st};
            return 1'b1;
        endfunction

        task report(string msg);
            if (mismatch_count < 50) $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_pixel(logic [31:0] argb, logic status);
            bit [31:0] want;
            bit        want_st;
            if (pending_argb.size() == 0) begin
                report($sformatf("result with no request pending, argb %h status %b",
                                 argb, status));
                return;
            end
            want = pending_argb.pop_front();
            want_st = pending_status.pop_front();
            if (argb !== want) report($sformatf("argb_out %h, predicted %h", argb, want));
            if (status !== want_st) report($sformatf("status %b, predicted %b", status, want_st));
        endtask
    endclass

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic                                   s_cmd = 1'b0;
    logic [lz3up_pkg::COORD_W-1:0]          s_col = '0;
    logic [lz3up_pkg::COORD_W-1:0]          s_row = '0;
    logic [lz3up_pkg::PIX_W-1:0]            s_argb_in = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic [lz3up_pkg::PIX_W-1:0]            m_argb_out;
    logic                                   m_status;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [lz3up_pkg::REG_IDX_W-1:0]        cfg_index = '0;
    logic [lz3up_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    resample_tracker tracker = new();
    int burst_left = 0;
    int item_total = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    lanczos3_image_upscaler_unit uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_col(s_col),
        .s_row(s_row),
        .s_argb_in(s_argb_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_argb_out(m_argb_out),
        .m_status(m_status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: ready runs and stalls of random length, now and then a long run
    always @(posedge aclk) begin
        if (m_valid && m_ready) tracker.check_pixel(m_argb_out, m_status);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            hold_left <= ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(4, 20);
        end else begin
            m_ready <= 1'b1;
            hold_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit [31:0] random_pixel();
        bit [31:0] v;
        int        c;
        v = $urandom;
        // saturated channels push the kernel into overshoot
        if ($urandom_range(0, 2) == 0) begin
            for (c = 0; c < 4; c++) v[8*c +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
        return v;
    endfunction

    task automatic send_item(bit cmd, bit [7:0] col, bit [7:0] row, bit [31:0] argb);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_col <= col;
        s_row <= row;
        s_argb_in <= argb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tracker.note_request(cmd, col, row, argb)) item_total++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending_argb.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_reg(idx, data);
    endtask

    task automatic configure(bit [2:0] sc, bit [6:0] w, bit [6:0] h, bit poke_spare);
        if (poke_spare) write_reg(REG_SPARE, 7'($urandom));
        write_reg(lz3up_pkg::REG_SCALE, {4'($urandom), sc});
        write_reg(lz3up_pkg::REG_SRC_WIDTH, w);
        write_reg(lz3up_pkg::REG_SRC_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_stray_write(int unsigned ew, int unsigned eh);
        if ($urandom_range(0, 1) != 0) begin
            send_item(lz3up_pkg::CMD_WRITE, 8'($urandom_range(ew, 255)), 8'($urandom),
                      random_pixel());
        end else begin
            send_item(lz3up_pkg::CMD_WRITE, 8'($urandom), 8'($urandom_range(eh, 255)),
                      random_pixel());
        end
    endtask

    // fill the whole source frame, then mix requests with updates and noise
    task automatic run_phase(bit [2:0] sc, bit [6:0] w, bit [6:0] h, int n_ops);
        int unsigned ew, eh, dw, dh;
        int          x, y, n;
        wait_idle();
        configure(sc, w, h, $urandom_range(0, 7) == 0);
        ew = tracker.source_width();
        eh = tracker.source_height();
        dw = ew * tracker.upscale_factor();
        dh = eh * tracker.upscale_factor();
        for (y = 0; y < eh; y++) begin
            for (x = 0; x < ew; x++) begin
                if ($urandom_range(0, 15) == 0) send_stray_write(ew, eh);
                send_item(lz3up_pkg::CMD_WRITE, 8'(x), 8'(y), random_pixel());
            end
        end
        for (n = 0; n < n_ops; n++) begin
            case ($urandom_range(0, 9))
                0: send_item(lz3up_pkg::CMD_WRITE, 8'($urandom_range(0, ew - 1)),
                             8'($urandom_range(0, eh - 1)), random_pixel());
                1: send_stray_write(ew, eh);
                2: begin
                    if (dw < 256) begin
                        send_item(lz3up_pkg::CMD_READ, 8'($urandom_range(dw, 255)),
                                  8'($urandom), $urandom);
                    end else if (dh < 256) begin
                        send_item(lz3up_pkg::CMD_READ, 8'($urandom),
                                  8'($urandom_range(dh, 255)), $urandom);
                    end
                end
                3: send_item(lz3up_pkg::CMD_READ,
                             ($urandom_range(0, 1) != 0) ? 8'd0 : 8'(dw - 1),
                             ($urandom_range(0, 1) != 0) ? 8'd0 : 8'(dh - 1), $urandom);
                default: send_item(lz3up_pkg::CMD_READ, 8'($urandom_range(0, dw - 1)),
                                   8'($urandom_range(0, dh - 1)), $urandom);
            endcase
        end
    endtask

    initial begin
        bit [2:0] sc;
        bit [6:0] w, h;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: pass-through over a 64x64 source
        send_item(lz3up_pkg::CMD_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(lz3up_pkg::CMD_WRITE, 8'd63, 8'd63, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_WRITE, 8'd0, 8'd63, 32'h807F_01FE);
        send_item(lz3up_pkg::CMD_WRITE, 8'd64, 8'd0, 32'h1234_5678);
        send_item(lz3up_pkg::CMD_WRITE, 8'd255, 8'd255, 32'hA5A5_A5A5);
        send_item(lz3up_pkg::CMD_READ, 8'd0, 8'd0, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd63, 8'd63, 32'hFFFF_FFFF);
        send_item(lz3up_pkg::CMD_READ, 8'd0, 8'd63, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd64, 8'd0, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd255, 8'd255, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd0, 8'd255, 32'h0000_0000);

        // 2x2 checkerboard at scale 2: ringing clamps at both rails
        wait_idle();
        configure(3'd2, 7'd2, 7'd2, 1'b1);
        send_item(lz3up_pkg::CMD_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(lz3up_pkg::CMD_WRITE, 8'd1, 8'd0, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_WRITE, 8'd0, 8'd1, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_WRITE, 8'd1, 8'd1, 32'hFFFF_FFFF);
        send_item(lz3up_pkg::CMD_READ, 8'd0, 8'd0, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd3, 8'd3, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd1, 8'd2, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd4, 8'd0, 32'h0000_0000);
        send_item(lz3up_pkg::CMD_READ, 8'd0, 8'd4, 32'h0000_0000);

        // widest and tallest frames, zero and saturating sizes, odd scales
        run_phase(3'd4, 7'd64, 7'd2, 30);
        run_phase(3'd4, 7'd1, 7'd64, 30);
        run_phase(3'd3, 7'd0, 7'd127, 20);
        run_phase(3'd0, 7'd127, 7'd0, 15);
        run_phase(3'd7, 7'd5, 7'd3, 15);

        while (item_total < ITEM_GOAL) begin
            sc = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(2, 4));
            case ($urandom_range(0, 9))
                0: begin
                    w = 7'($urandom_range(64, 127));
                    h = 7'($urandom_range(0, 3));
                end
                1: begin
                    w = 7'($urandom_range(0, 3));
                    h = 7'($urandom_range(64, 127));
                end
                2: begin
                    w = 7'($urandom_range(0, 1));
                    h = 7'($urandom_range(0, 1));
                end
                default: begin
                    w = 7'($urandom_range(1, 10));
                    h = 7'($urandom_range(1, 10));
                end
            endcase
            run_phase(sc, w, h, $urandom_range(10, 40));
        end

        wait_idle();
        if (tracker.mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lz3up_pkg.sv
hw/rtl/lz3up_frame_ram.sv
hw/rtl/lz3up_seq.sv
hw/rtl/lz3up_mac.sv
hw/rtl/lanczos3_image_upscaler_unit.sv
test/lanczos3_image_upscaler_unit_tb.sv
